FILE: hw/rtl/trivium_byte_stream_cipher_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Trivium byte stream cipher unit
// Concurrent checks that compile away when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef TRIVIUM_BYTE_STREAM_CIPHER_UNIT_ASSERT_SVH
`define TRIVIUM_BYTE_STREAM_CIPHER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Check held off while reset is asserted (active low reset).
`define TRIV_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check that also runs during reset.
`define TRIV_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define TRIV_ASSERT(lbl, clk, rstn, prop, msg)
`define TRIV_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

FILE: hw/rtl/triv_pkg.sv
// ----------------------------------------------------------------------------
// triv_pkg
// Types, constants and the eight-round Trivium update shared by the unit.
// ----------------------------------------------------------------------------
`default_nettype none

package triv_pkg;

  localparam int unsigned StateBits  = 288;
  localparam int unsigned KeyBits    = 80;
  localparam int unsigned IvBits     = 80;
  localparam int unsigned IvBase     = 93;
  localparam int unsigned RoundsStep = 8;
  localparam int unsigned WarmRounds = 4 * StateBits;
  localparam int unsigned WarmSteps  = WarmRounds / RoundsStep;   // 144
  localparam int unsigned CntW       = $clog2(WarmSteps);
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 64;
  localparam int unsigned HighW      = 16;

  typedef logic [StateBits-1:0] triv_state_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_KEY_LOW  = 3'd0,
    CFG_KEY_HIGH = 3'd1,
    CFG_IV_LOW   = 3'd2,
    CFG_IV_HIGH  = 3'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WARM,
    ST_EMIT
  } ctrl_state_e;

  // Controller -> datapath commands
  typedef struct packed {
    logic load;      // load key/IV into cipher state
    logic capture;   // hold the input byte for later
    logic advance;   // run eight rounds
    logic emit;      // write result register
    logic use_held;  // result taken from held byte, not the port
  } dp_cmd_t;

  typedef struct packed {
    triv_state_t st;
    logic [7:0]  ks;
  } triv_step_t;

  // One Trivium round on a bit-indexed state (bit i is s[i+1]).
  function automatic triv_state_t triv_round(input triv_state_t s, output logic z);
    logic        t1, t2, t3;
    triv_state_t n;
    t1 = s[65] ^ s[92];
    t2 = s[161] ^ s[176];
    t3 = s[242] ^ s[287];
    z  = t1 ^ t2 ^ t3;
    t1 = t1 ^ (s[90] & s[91]) ^ s[170];
    t2 = t2 ^ (s[174] & s[175]) ^ s[263];
    t3 = t3 ^ (s[285] & s[286]) ^ s[68];
    n           = s;
    n[92:1]     = s[91:0];
    n[0]        = t3;
    n[176:94]   = s[175:93];
    n[93]       = t1;
    n[287:178]  = s[286:177];
    n[177]      = t2;
    return n;
  endfunction

  // Eight rounds; first keystream bit lands in bit 7.
  function automatic triv_step_t triv_round8(input triv_state_t s);
    triv_step_t r;
    logic       z;
    r.st = s;
    r.ks = '0;
    for (int i = 0; i < RoundsStep; i++) begin
      r.st = triv_round(r.st, z);
      r.ks[RoundsStep-1-i] = z;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/trivium_byte_stream_cipher_unit.sv
// ----------------------------------------------------------------------------
// trivium_byte_stream_cipher_unit
// Trivium (80-bit key, 80-bit IV) keystream XOR, one data byte per beat.
// ----------------------------------------------------------------------------
//
//   channel | signals                                  | direction
//   --------+------------------------------------------+----------
//   in      | in_valid_i/in_ready_o, data_byte_i,      | sink
//           | restart_i                                |
//   out     | out_valid_o/out_ready_i, result_byte_o   | source
//   cfg     | cfg_we_i, cfg_idx_i, cfg_data_i          | write only
//
// Streaming: for a beat without warm-up the 288-bit state runs eight rounds
//   per clock and the result register shows the byte the next cycle, so
//   such beats stream at one per cycle while out_ready_i is high.
// Warm-up (first beat after reset, or restart set): key/IV is loaded and the
//   byte held, ST_WARM runs 1152 rounds, then ST_EMIT writes the byte.
// Reset: asynchronous, active low; clears key/IV, primed flag and handshakes.
// Stalls: a pending result beat holds in the output register; while it is
//   pending, input is taken only in the same cycle the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module trivium_byte_stream_cipher_unit import triv_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input beats
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          data_byte_i,
  input  logic                restart_i,
  // result beats
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          result_byte_o,
  // configuration writes: 0 key_low, 1 key_high, 2 iv_low, 3 iv_high
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  dp_cmd_t cmd;

  // Sequencer: decides load / warm-up / emit and owns the out valid flag.
  triv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .restart_i   (restart_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // Datapath: key/IV, cipher state, eight-round update, result byte.
  triv_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .data_byte_i   (data_byte_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .result_byte_o (result_byte_o)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/triv_dp.sv
// ----------------------------------------------------------------------------
// triv_dp
// Datapath: key/IV registers, 288-bit cipher state, 8-round update, result.
// ----------------------------------------------------------------------------
`default_nettype none

module triv_dp import triv_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dp_cmd_t             cmd_i,
  input  logic [7:0]          data_byte_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output logic [7:0]          result_byte_o
);

  logic [KeyBits-1:0] key_q;
  logic [IvBits-1:0]  iv_q;
  triv_state_t        state_q, state_d;
  logic [7:0]         data_q;
  logic [7:0]         res_q;
  triv_step_t         step;
  logic [7:0]         src;
  triv_state_t        load_val;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
      iv_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_KEY_LOW:  key_q[CfgDataW-1:0]       <= cfg_data_i;
        CFG_KEY_HIGH: key_q[KeyBits-1:CfgDataW] <= cfg_data_i[HighW-1:0];
        CFG_IV_LOW:   iv_q[CfgDataW-1:0]        <= cfg_data_i;
        CFG_IV_HIGH:  iv_q[IvBits-1:CfgDataW]   <= cfg_data_i[HighW-1:0];
        default: ;  // unmapped index: ignored
      endcase
    end
  end

  always_comb begin
    load_val = '0;
    load_val[KeyBits-1:0]              = key_q;
    load_val[IvBase+IvBits-1:IvBase]   = iv_q;
    load_val[StateBits-1:StateBits-3]  = 3'b111;
  end

  assign step = triv_round8(state_q);
  assign src  = cmd_i.use_held ? data_q : data_byte_i;

  always_comb begin
    state_d = state_q;
    if (cmd_i.load) begin
      state_d = load_val;
    end else if (cmd_i.advance) begin
      state_d = step.st;
    end
  end

  always_ff @(posedge clk_i) begin
    state_q <= state_d;
    if (cmd_i.capture) begin
      data_q <= data_byte_i;
    end
    if (cmd_i.emit) begin
      res_q <= src ^ step.ks;
    end
  end

  assign result_byte_o = res_q;

endmodule

`default_nettype wire

FILE: hw/rtl/triv_ctrl.sv
// ----------------------------------------------------------------------------
// triv_ctrl
// Sequencer: input/output handshakes, primed flag and warm-up counter.
// ----------------------------------------------------------------------------
`default_nettype none
`include "trivium_byte_stream_cipher_unit_assert.svh"

module triv_ctrl import triv_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  logic    restart_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output dp_cmd_t cmd_o
);

  ctrl_state_e     state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            primed_q, primed_d;
  logic            out_valid_q, out_valid_d;
  logic            accept;
  logic            need_warm;

  assign in_ready_o  = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign need_warm   = restart_i || !primed_q;
  assign out_valid_o = out_valid_q;

  // next state
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    primed_d = primed_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && need_warm) begin
          state_d  = ST_WARM;
          cnt_d    = CntW'(WarmSteps - 1);
          primed_d = 1'b1;
        end
      end
      ST_WARM: begin
        if (cnt_q == '0) begin
          state_d = ST_EMIT;
        end else begin
          cnt_d = cnt_q - CntW'(1);
        end
      end
      ST_EMIT: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (need_warm) begin
            cmd_o.load    = 1'b1;
            cmd_o.capture = 1'b1;
          end else begin
            cmd_o.advance = 1'b1;
            cmd_o.emit    = 1'b1;
          end
        end
      end
      ST_WARM: cmd_o.advance = 1'b1;
      ST_EMIT: begin
        cmd_o.advance  = 1'b1;
        cmd_o.emit     = 1'b1;
        cmd_o.use_held = 1'b1;
      end
      default: cmd_o = '0;
    endcase
  end

  always_comb begin
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      primed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      primed_q    <= primed_d;
      out_valid_q <= out_valid_d;
    end
  end

  `TRIV_ASSERT(a_ready_only_idle, clk_i, rst_ni, (state_q != ST_IDLE) |-> !in_ready_o, "input ready outside idle")
  `TRIV_ASSERT(a_warm_to_emit, clk_i, rst_ni, (state_q == ST_WARM && cnt_q == '0) |=> (state_q == ST_EMIT), "warm-up did not end in emit")
  `TRIV_ASSERT(a_emit_slot_free, clk_i, rst_ni, (state_q == ST_EMIT) |-> !out_valid_q, "held result would overwrite pending beat")
  `TRIV_ASSERT(a_restart_warms, clk_i, rst_ni, (accept && restart_i) |=> (state_q == ST_WARM && cnt_q == CntW'(WarmSteps - 1)), "restart beat skipped warm-up")
  `TRIV_ASSERT(a_primed_when_busy, clk_i, rst_ni, (state_q != ST_IDLE) |-> primed_q, "working on unprimed state")

endmodule

`default_nettype wire
